// File: design/assert_macros.svh
// Assertion macros shared by the design files.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/n2ew_pkg.sv
// Package for the number-to-words block: transaction types, word and joiner codes.
// No dependencies.
`timescale 1ns / 1ps

package n2ew_pkg;

  localparam int unsigned VALUE_W = 61;

  localparam logic [5:0] W_ZERO     = 6'd0;
  localparam logic [5:0] W_TWO      = 6'd2;
  localparam logic [5:0] W_TENS0    = 6'd18;
  localparam logic [5:0] W_HUNDRED  = 6'd28;
  localparam logic [5:0] W_SCALE0   = 6'd28;
  localparam logic [5:0] W_THOUSAND = 6'd29;
  localparam logic [5:0] W_AND      = 6'd34;
  localparam logic [5:0] W_MINUS    = 6'd35;
  localparam logic [5:0] W_OH       = 6'd36;

  localparam logic [1:0] J_NONE   = 2'd0;
  localparam logic [1:0] J_SPACE  = 2'd1;
  localparam logic [1:0] J_HYPHEN = 2'd2;
  localparam logic [1:0] J_COMMA  = 2'd3;

  localparam logic [1:0] OP_PLAIN   = 2'd0;
  localparam logic [1:0] OP_ORDINAL = 2'd1;
  localparam logic [1:0] OP_YEAR    = 2'd2;

  localparam logic [VALUE_W-1:0] YEAR_LO = VALUE_W'(1000);
  localparam logic [VALUE_W-1:0] YEAR_HI = VALUE_W'(3000);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [1:0]                operation;
  } in_t;

  typedef struct packed {
    logic [5:0] word;
    logic [1:0] joiner;
    logic       ordinal_form;
    logic       last;
  } out_t;

  // Word for a two-digit pair 0..99 when it is a single token (below twenty),
  // otherwise the tens word.
  function automatic logic [5:0] pair_word(input logic [3:0] t, input logic [3:0] o);
    logic [5:0] r;
    if (t < 4'd2) begin
      r = ((t == 4'd1) ? 6'd10 : 6'd0) + {2'b00, o};
    end else begin
      r = W_TENS0 + {2'b00, t};
    end
    return r;
  endfunction

endpackage

// File: design/number_to_english_word_tokens.sv
// Top level of the number-to-words block: conversion sequencer and word emitter.
// Depends on n2ew_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// A transaction is accepted on a rising edge where start is high and busy is low;
// in_data carries the signed value and the operation. busy then stays high until
// the final word has been delivered, and no new transaction is taken meanwhile.
// The magnitude is turned into BCD by a shift-and-add-three converter, one bit a
// cycle. The same correct-and-shift step is applied to every digit at once and
// reused on every cycle. The word stage then walks the digit groups from the top,
// six slots per group; a year reading uses one pass. Words leave on out_data, each
// marked by out_valid for exactly one cycle; the last word carries out_data.last.
// The receiver cannot stall, so every word is taken as it is shown. A word is held
// back in a register until its successor is known, so that the last mark can be
// set. Reset returns the sequencer to idle and drops any word in flight; there is
// no stored state beyond that.
module number_to_english_word_tokens
  import n2ew_pkg::*;
#(
  parameter int unsigned MAX_GROUPS = 6
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  // Digits kept by the converter: the groups, plus one spare so that a year
  // always has its thousands digit even with a single group.
  localparam int unsigned NGD = 3 * MAX_GROUPS;
  localparam int unsigned ND  = NGD + 1;
  localparam int unsigned GW  = $clog2(MAX_GROUPS + 1);
  localparam int unsigned NSLOT = 6;
  localparam logic [2:0] SLOT_END = 3'(NSLOT - 1);
  localparam logic [5:0] CONV_END = 6'(VALUE_W - 1);

  typedef enum logic [2:0] {S_IDLE, S_CONV, S_PLAN, S_EMIT, S_FLUSH} state_t;

  state_t               state_r;
  logic [VALUE_W-1:0]   mag_r;
  logic                 neg_r;
  logic [1:0]           op_r;
  logic                 yr_r;
  logic [5:0]           cnt_r;
  logic [4*ND-1:0]      bcd_r;
  logic [4*ND-1:0]      bcd_nxt;
  logic [GW-1:0]        grp_r;
  logic [2:0]           slot_r;
  logic                 started_r;
  logic                 pend_v_r;
  logic [5:0]           pend_w_r;
  logic [1:0]           pend_j_r;
  logic                 out_valid_r;
  out_t                 out_data_r;

  logic [VALUE_W-1:0]   mag_in;
  logic                 any_nz;
  logic                 grp_nz;
  logic                 prod_v;
  logic [5:0]           prod_w;
  logic [1:0]           prod_j;
  logic                 slot_v [NSLOT];
  logic [5:0]           slot_w [NSLOT];
  logic [1:0]           slot_j [NSLOT];

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Magnitude of the two's complement input; the most negative value maps onto
  // itself, which is the correct unsigned magnitude.
  assign mag_in = in_data.value[VALUE_W-1] ? (~in_data.value + 1'b1) : in_data.value;

  // One converter step: correct every digit of five or more, then shift the
  // next magnitude bit in.
  always_comb begin
    logic [4*ND-1:0] adj;
    adj = bcd_r;
    for (int i = 0; i < ND; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end
    end
    bcd_nxt = {adj[4*ND-2:0], mag_r[VALUE_W-1]};
  end

  assign any_nz = |bcd_r[4*NGD-1:0];

  // Word slots for the current group, or for the year reading.
  always_comb begin
    logic [3:0] h, t, o, th, yh;
    logic [1:0] j0, rj;
    logic       rnz;
    j0 = J_NONE;
    rj = J_NONE;
    h  = bcd_r[4*NGD-1 -: 4];
    t  = bcd_r[4*NGD-5 -: 4];
    o  = bcd_r[4*NGD-9 -: 4];
    th = bcd_r[15:12];
    yh = bcd_r[11:8];
    rnz = (t != 4'd0) || (o != 4'd0);
    grp_nz = (h != 4'd0) || rnz;
    for (int i = 0; i < NSLOT; i++) begin
      slot_v[i] = 1'b0;
      slot_w[i] = W_ZERO;
      slot_j[i] = J_SPACE;
    end
    if (yr_r) begin
      t = bcd_r[7:4];
      o = bcd_r[3:0];
      if (th == 4'd2 && yh == 4'd0 && t == 4'd0) begin
        // Two thousand, optionally followed by a single digit.
        slot_v[0] = 1'b1; slot_w[0] = W_TWO; slot_j[0] = J_NONE;
        slot_v[1] = 1'b1; slot_w[1] = W_THOUSAND;
        slot_v[2] = (o != 4'd0); slot_w[2] = {2'b00, o};
      end else begin
        slot_v[0] = 1'b1; slot_w[0] = pair_word(th, yh); slot_j[0] = J_NONE;
        slot_v[1] = (th >= 4'd2) && (yh != 4'd0);
        slot_w[1] = {2'b00, yh}; slot_j[1] = J_HYPHEN;
        if (t == 4'd0 && o == 4'd0) begin
          slot_v[2] = 1'b1; slot_w[2] = W_HUNDRED;
        end else if (t == 4'd0) begin
          slot_v[2] = 1'b1; slot_w[2] = W_OH;
          slot_v[3] = 1'b1; slot_w[3] = {2'b00, o};
        end else begin
          slot_v[2] = 1'b1; slot_w[2] = pair_word(t, o);
          slot_v[3] = (t >= 4'd2) && (o != 4'd0);
          slot_w[3] = {2'b00, o}; slot_j[3] = J_HYPHEN;
        end
      end
    end else begin
      if (started_r) begin
        j0 = (h != 4'd0) ? J_COMMA : J_SPACE;
      end else begin
        j0 = neg_r ? J_SPACE : J_NONE;
      end
      rj = (h != 4'd0) ? J_SPACE : j0;
      slot_v[0] = (h != 4'd0); slot_w[0] = {2'b00, h}; slot_j[0] = j0;
      slot_v[1] = (h != 4'd0); slot_w[1] = W_HUNDRED;
      slot_v[2] = (h != 4'd0) && rnz && (op_r == OP_ORDINAL); slot_w[2] = W_AND;
      slot_v[3] = rnz; slot_w[3] = pair_word(t, o); slot_j[3] = rj;
      slot_v[4] = (t >= 4'd2) && (o != 4'd0);
      slot_w[4] = {2'b00, o}; slot_j[4] = J_HYPHEN;
      slot_v[5] = (grp_r != '0); slot_w[5] = W_SCALE0 + 6'(grp_r);
    end
  end

  // The word produced in this cycle, if any.
  always_comb begin
    prod_v = 1'b0;
    prod_w = W_ZERO;
    prod_j = J_NONE;
    unique case (state_r)
      S_PLAN: begin
        if (!yr_r && !any_nz) begin
          prod_v = 1'b1;
        end else if (!yr_r && neg_r) begin
          prod_v = 1'b1;
          prod_w = W_MINUS;
        end
      end
      S_EMIT: begin
        prod_v = slot_v[slot_r] && (yr_r || grp_nz);
        prod_w = slot_w[slot_r];
        prod_j = slot_j[slot_r];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_valid_r <= 1'b0;
    if (prod_v) begin
      // The held word is released once a successor exists, so it is not last.
      if (pend_v_r) begin
        out_valid_r <= 1'b1;
        out_data_r  <= '{word: pend_w_r, joiner: pend_j_r, ordinal_form: 1'b0, last: 1'b0};
      end
      pend_v_r <= 1'b1;
      pend_w_r <= prod_w;
      pend_j_r <= prod_j;
    end
    unique case (state_r)
      S_IDLE: begin
        pend_v_r <= 1'b0;
        if (start) begin
          mag_r   <= mag_in;
          neg_r   <= in_data.value[VALUE_W-1];
          op_r    <= in_data.operation;
          bcd_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_CONV;
        end
      end
      S_CONV: begin
        if (cnt_r == '0) begin
          yr_r <= (op_r == OP_YEAR) && !neg_r && (mag_r > YEAR_LO) && (mag_r < YEAR_HI);
        end
        bcd_r <= bcd_nxt;
        mag_r <= {mag_r[VALUE_W-2:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == CONV_END) begin
          state_r <= S_PLAN;
        end
      end
      S_PLAN: begin
        slot_r    <= '0;
        grp_r     <= GW'(MAX_GROUPS - 1);
        started_r <= 1'b0;
        state_r   <= (yr_r || any_nz) ? S_EMIT : S_FLUSH;
      end
      S_EMIT: begin
        if (slot_r == SLOT_END) begin
          if (yr_r || grp_r == '0) begin
            state_r <= S_FLUSH;
          end else begin
            grp_r     <= grp_r - 1'b1;
            bcd_r     <= {bcd_r[4*ND-13:0], 12'h000};
            slot_r    <= '0;
            started_r <= started_r || grp_nz;
          end
        end else begin
          slot_r <= slot_r + 3'd1;
        end
      end
      S_FLUSH: begin
        out_valid_r <= 1'b1;
        out_data_r  <= '{word: pend_w_r, joiner: pend_j_r,
                         ordinal_form: (op_r == OP_ORDINAL), last: 1'b1};
        pend_v_r    <= 1'b0;
        state_r     <= S_IDLE;
      end
      default: begin
        state_r <= S_IDLE;
      end
    endcase
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end
  end

  `ASSERT_NXT(a_last_ends, out_valid && out_data.last, !out_valid, "word after last word")
  `ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted transaction not busy")
  `ASSERT_IMP(a_ord_last, out_valid && out_data.ordinal_form, out_data.last, "ordinal not last")

endmodule

// File: dv/testbench.sv
// Self-checking testbench for number_to_english_word_tokens: drives signed values and modes,
// predicts every word token and compares each strobed result against the oldest prediction.
// Depends on n2ew_pkg and the design files.
`timescale 1ns / 1ps

module testbench;
  import n2ew_pkg::*;

  localparam int unsigned GROUPS = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned RANDOM_ITEMS = 350;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  number_to_english_word_tokens #(.MAX_GROUPS(GROUPS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // The clock runs at 125 MHz: four nanoseconds high, four low.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Words still owed by the block, oldest at the front.
  out_t pending_words[$];
  int unsigned mismatches;
  int unsigned words_seen;
  int unsigned numbers_sent;
  int unsigned idle_cycles;
  int unsigned sender_idle_pct;

  // One row of the directed stimulus. Where the expected words are typed in, they are
  // checked against what the predictor gives as well, so a slip in either one shows up.
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [1:0]                operation;
    int                        typed_count;
    logic [5:0]                typed_word[4];
  } stim_row_t;

  stim_row_t directed_rows[$];

  // The predicted words of the current number are collected here before being queued.
  out_t spoken[$];

  function automatic void emit_word(input logic [5:0] w, input logic [1:0] j);
    out_t t;
    t.word = w;
    t.joiner = j;
    t.ordinal_form = 1'b0;
    t.last = 1'b0;
    if (spoken.size() < 37) spoken.push_back(t);
  endfunction

  // A pair 0..99: below twenty it is one word, otherwise a tens word and, unless the unit is zero, a hyphenated unit.
  function automatic void speak_pair(input int unsigned v, input logic [1:0] j);
    if (v < 20) begin
      emit_word(6'(v), j);
    end else begin
      emit_word(6'(18 + v / 10), j);
      if (v % 10 != 0) emit_word(6'(v % 10), J_HYPHEN);
    end
  endfunction

  function automatic void speak_group(input int unsigned v, input logic [1:0] j, input bit with_and);
    int unsigned h;
    int unsigned r;
    logic [1:0] jj;
    h = v / 100;
    r = v % 100;
    jj = j;
    if (h != 0) begin
      emit_word(6'(h), jj);
      emit_word(W_HUNDRED, J_SPACE);
      jj = J_SPACE;
    end
    if (r != 0) begin
      if (h != 0 && with_and) emit_word(W_AND, J_SPACE);
      speak_pair(r, jj);
    end
  endfunction

  function automatic void speak_cardinal(input logic [63:0] mag_in, input bit neg, input bit with_and);
    int unsigned grp[GROUPS];
    int n;
    bit any;
    bit begun;
    logic [63:0] mag;
    logic [1:0] j;
    n = 0;
    any = 0;
    begun = 0;
    mag = mag_in;
    while (mag > 0 && n < GROUPS) begin
      grp[n] = int'(mag % 1000);
      if (grp[n] != 0) any = 1;
      mag = mag / 1000;
      n++;
    end
    if (!any) begin
      emit_word(W_ZERO, J_NONE);
      return;
    end
    if (neg) emit_word(W_MINUS, J_NONE);
    for (int g = n - 1; g >= 0; g--) begin
      if (grp[g] == 0) continue;
      if (begun) j = (grp[g] >= 100) ? J_COMMA : J_SPACE;
      else j = neg ? J_SPACE : J_NONE;
      speak_group(grp[g], j, with_and);
      if (g > 0) emit_word(6'(W_SCALE0 + g), J_SPACE);
      begun = 1;
    end
  endfunction

  function automatic void speak_year(input int unsigned v);
    int unsigned hi;
    int unsigned lo;
    hi = v / 100;
    lo = v % 100;
    if (v == 2000) begin
      emit_word(W_TWO, J_NONE);
      emit_word(W_THOUSAND, J_SPACE);
    end else if (v > 2000 && v < 2010) begin
      emit_word(W_TWO, J_NONE);
      emit_word(W_THOUSAND, J_SPACE);
      emit_word(6'(lo), J_SPACE);
    end else if (lo == 0) begin
      speak_pair(hi, J_NONE);
      emit_word(W_HUNDRED, J_SPACE);
    end else begin
      speak_pair(hi, J_NONE);
      if (lo < 10) begin
        emit_word(W_OH, J_SPACE);
        emit_word(6'(lo), J_SPACE);
      end else begin
        speak_pair(lo, J_SPACE);
      end
    end
  endfunction

  // Works out the full run of words for one number and leaves it in spoken.
  function automatic void predict_words(input logic signed [VALUE_W-1:0] value,
                                        input logic [1:0] op);
    bit neg;
    logic [VALUE_W-1:0] raw;
    logic [63:0] mag;
    spoken.delete();
    raw = value;
    neg = raw[VALUE_W-1];
    mag = neg ? 64'(VALUE_W'(-raw)) : 64'(raw);
    if (op == OP_YEAR && !neg && mag > 1000 && mag < 3000) speak_year(int'(mag));
    else speak_cardinal(mag, neg, op == OP_ORDINAL);
    if (spoken.size() > 0) begin
      spoken[spoken.size() - 1].last = 1'b1;
      if (op == OP_ORDINAL) spoken[spoken.size() - 1].ordinal_form = 1'b1;
    end
  endfunction

  function automatic void add_row(input logic signed [VALUE_W-1:0] v, input logic [1:0] op,
                                  input int cnt, input logic [5:0] w0 = 0,
                                  input logic [5:0] w1 = 0, input logic [5:0] w2 = 0,
                                  input logic [5:0] w3 = 0);
    stim_row_t r;
    r.value = v;
    r.operation = op;
    r.typed_count = cnt;
    r.typed_word[0] = w0;
    r.typed_word[1] = w1;
    r.typed_word[2] = w2;
    r.typed_word[3] = w3;
    directed_rows.push_back(r);
  endfunction

  // Random magnitude: a year 1001..2999 a quarter of the time, else up to eighteen digits with
  // all group widths reached, and now and then the whole 61-bit field, beyond eighteen digits.
  function automatic logic signed [VALUE_W-1:0] random_value();
    logic [63:0] m;
    int unsigned pick;
    int unsigned digits;
    logic [63:0] lim;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      m = {$urandom(), $urandom()};
      return VALUE_W'(m);
    end
    if (pick < 35) begin
      m = 64'($urandom_range(1001, 2999));
      return VALUE_W'(m);
    end
    digits = $urandom_range(1, 18);
    lim = 1;
    for (int i = 0; i < digits; i++) lim = lim * 10;
    m = {$urandom(), $urandom()} % lim;
    // Now and then knock out the thousands group so that zero groups occur, and alter the hundred-millions digit.
    if ($urandom_range(0, 2) == 0) m = m - (m / 1000 % 1000) * 1000;
    if ($urandom_range(0, 3) == 0) m = m - (m / 1000000 % 10) * 1000000 * 100;
    if ($urandom_range(0, 3) == 0) return -VALUE_W'(m);
    return VALUE_W'(m);
  endfunction

  // Offers one number on a falling edge and holds it until the block takes it.
  task automatic send_number(input logic signed [VALUE_W-1:0] value, input logic [1:0] op);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) @(negedge clk);
    in_data.value <= value;
    in_data.operation <= op;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // The words are queued at the edge of acceptance, before any can come out.
    predict_words(value, op);
    foreach (spoken[i]) pending_words.push_back(spoken[i]);
    numbers_sent++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Compares every strobed word with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: word %0d arrived with nothing expected", out_data.word);
      end else begin
        out_t exp_w;
        exp_w = pending_words.pop_front();
        if (out_data !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: expected word %0d join %0d ord %0b last %0b, got %0d %0d %0b %0b",
                     exp_w.word, exp_w.joiner, exp_w.ordinal_form, exp_w.last,
                     out_data.word, out_data.joiner, out_data.ordinal_form, out_data.last);
        end
      end
    end
  end

  // Watchdog: counts cycles with neither an accepted number nor a delivered word.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out with %0d words still expected", pending_words.size());
      $display("FAIL number_to_english_word_tokens");
      $finish;
    end
  end

  initial begin
    logic signed [VALUE_W-1:0] big;
    logic [1:0] op;
    start = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    mismatches = 0;
    words_seen = 0;
    numbers_sent = 0;
    sender_idle_pct = 6;
    big = VALUE_W'(64'd999999999999999999);

    // Directed rows: zero in each mode, extremes, years and their corner cases, operation 3.
    add_row('0, OP_PLAIN, 1, W_ZERO);
    add_row('0, OP_ORDINAL, 1, W_ZERO);
    add_row('0, OP_YEAR, 1, W_ZERO);
    add_row(VALUE_W'(7), 2'd3, 1, 6'd7);
    add_row(-VALUE_W'(1), OP_PLAIN, 2, W_MINUS, 6'd1);
    add_row(VALUE_W'(2000), OP_YEAR, 2, W_TWO, W_THOUSAND);
    add_row(VALUE_W'(2005), OP_YEAR, 3, W_TWO, W_THOUSAND, 6'd5);
    add_row(VALUE_W'(1900), OP_YEAR, 2, 6'd19, W_HUNDRED);
    add_row(VALUE_W'(1905), OP_YEAR, 3, 6'd19, W_OH, 6'd5);
    add_row(VALUE_W'(1000), OP_YEAR, 2, 6'd1, W_THOUSAND);
    add_row(VALUE_W'(1001), OP_YEAR, 0);
    add_row(VALUE_W'(2999), OP_YEAR, 0);
    add_row(VALUE_W'(3000), OP_YEAR, 0);
    add_row(VALUE_W'(2010), OP_YEAR, 0);
    add_row(-VALUE_W'(1984), OP_YEAR, 0);
    add_row(VALUE_W'(123), OP_ORDINAL, 0);
    add_row(VALUE_W'(1001001), OP_PLAIN, 0);
    add_row(VALUE_W'(1100045), OP_ORDINAL, 0);
    add_row(big, OP_PLAIN, 0);
    add_row(-big, OP_ORDINAL, 0);
    // Digits past eighteen are dropped; a lone one there leaves just zero.
    add_row(VALUE_W'(64'd1000000000000000000), OP_PLAIN, 1, W_ZERO);
    add_row(-VALUE_W'(64'd1000000000000000000), OP_PLAIN, 1, W_ZERO);
    add_row({1'b0, {(VALUE_W-1){1'b1}}}, OP_PLAIN, 0);
    add_row({1'b1, {(VALUE_W-1){1'b0}}}, OP_ORDINAL, 0);
    add_row(VALUE_W'(90), OP_ORDINAL, 0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed_count > 0) begin
        predict_words(directed_rows[i].value, directed_rows[i].operation);
        if (spoken.size() != directed_rows[i].typed_count) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: row %0d predicts %0d words", i, spoken.size());
        end else begin
          for (int k = 0; k < directed_rows[i].typed_count; k++)
            if (spoken[k].word !== directed_rows[i].typed_word[k]) begin
              mismatches++;
              if (mismatches <= 10) $display("ERROR: row %0d word %0d differs", i, k);
            end
        end
      end
      send_number(directed_rows[i].value, directed_rows[i].operation);
    end

    // Random part in three phases of sender idling: some, then much, then none.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) sender_idle_pct = 45;
      if (n == 2 * RANDOM_ITEMS / 3) sender_idle_pct = 0;
      op = 2'($urandom_range(0, 3));
      send_number(random_value(), op);
    end

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Spoke %0d numbers in every mode, %0d words checked", numbers_sent, words_seen);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("PASS number_to_english_word_tokens");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL number_to_english_word_tokens");
    end
    $finish;
  end

endmodule
